FILE: hdl/qbsd_pkg.sv
// Shared types, constants and floating-point helper functions for the Q8_0 dot product unit.
package qbsd_pkg;

    localparam int BLOCK_ELEMENTS = 32;
    localparam int LANES          = 8;
    localparam int DOT_STEPS      = BLOCK_ELEMENTS / LANES;
    localparam int DOT_W          = 21;
    localparam int BPR_W          = 14;
    localparam int ROWS_W         = 17;
    localparam int POS_W          = 13;
    localparam int ROW_W          = 16;
    localparam int CFG_DATA_W     = 17;

    localparam logic [BPR_W-1:0]  BPR_MAX  = 14'd8192;
    localparam logic [ROWS_W-1:0] ROWS_MAX = 17'd65536;
    localparam logic [31:0]       QNAN     = 32'h7FC00000;

    // Configuration register indexes
    typedef enum logic {
        CFG_BLOCKS_PER_ROW = 1'b0,
        CFG_ROW_COUNT      = 1'b1
    } cfg_index_t;

    // Unpacked fp32 operand: value = man/2^23 * 2^(exp-127), man normalized
    typedef struct packed {
        logic                sgn;
        logic signed [10:0]  exp;
        logic [23:0]         man;
        logic                zero;
        logic                inf;
        logic                nan;
    } fp_unp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic dot_step;
        logic mul_sel;
        logic mul_a;
        logic mul_b;
        logic mul_c;
        logic add_a;
        logic add_b;
        logic add_c;
        logic add_d;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic commit_stall;
    } dp_status_t;

    // Count leading zeros of a 48-bit word (48 when zero)
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    // Widen an fp16 bit pattern to fp32 (exact)
    function automatic logic [31:0] half_to_bits(input logic [15:0] h);
        logic [31:0] bits;
        logic [5:0]  z;
        logic [10:0] ms;
        bits = '0;
        z    = '0;
        ms   = '0;
        if (h[14:10] == 5'd0) begin
            if (h[9:0] == 10'd0) begin
                bits = {h[15], 31'd0};
            end else begin
                z    = lzc48({h[9:0], 38'd0});
                ms   = {1'b0, h[9:0]} << (z + 6'd1);
                bits = {h[15], 8'd112 - {2'b0, z}, ms[9:0], 13'd0};
            end
        end else if (h[14:10] == 5'd31) begin
            bits = {h[15], 8'hFF, h[9:0], 13'd0};
        end else begin
            bits = {h[15], {3'b0, h[14:10]} + 8'd112, h[9:0], 13'd0};
        end
        return bits;
    endfunction

    // Split an fp32 bit pattern into class flags and a normalized mantissa
    function automatic fp_unp_t unpack(input logic [31:0] b);
        fp_unp_t    u;
        logic [5:0] lz;
        u.sgn  = b[31];
        u.zero = (b[30:23] == 8'd0) && (b[22:0] == 23'd0);
        u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        lz     = lzc48({1'b0, b[22:0], 24'd0});
        if (b[30:23] == 8'd0) begin
            u.man = {1'b0, b[22:0]} << lz;
            u.exp = 11'sd1 - $signed({5'd0, lz});
        end else begin
            u.man = {1'b1, b[22:0]};
            u.exp = $signed({3'd0, b[30:23]});
        end
        return u;
    endfunction

    // Round to nearest even and pack; m has its leading one at bit 47,
    // value = m/2^47 * 2^(e-127)
    function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e,
                                               input logic [47:0] m);
        logic [31:0]        res;
        logic signed [11:0] shw;
        logic [5:0]         sh;
        logic [47:0]        mm;
        logic               sticky;
        logic [7:0]         ef;
        logic               rnd;
        shw    = 12'sd1 - e;
        sh     = '0;
        mm     = m;
        sticky = 1'b0;
        ef     = '0;
        if (e >= 12'sd255) begin
            res = {sgn, 8'hFF, 23'd0};
        end else begin
            if (e <= 12'sd0) begin
                sh     = (shw > 12'sd49) ? 6'd49 : shw[5:0];
                mm     = m >> sh;
                sticky = |(m & ~({48{1'b1}} << sh));
                ef     = 8'd0;
            end else begin
                ef = e[7:0];
            end
            rnd = mm[23] & ((|mm[22:0]) | sticky | mm[24]);
            res = {sgn, ef, mm[46:24]} + {31'd0, rnd};
        end
        return res;
    endfunction

endpackage

FILE: hdl/qbsd_ctrl.sv
// Sequencing state machine for the Q8_0 dot product unit.
module qbsd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  qbsd_pkg::dp_status_t  status,
    output qbsd_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_ADD_A,
        ST_ADD_B,
        ST_ADD_C,
        ST_ADD_D,
        ST_COMMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pass_reg, pass_next;

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next  = '0;
                pass_next = 1'b0;
                if (s_tvalid) begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'(qbsd_pkg::DOT_STEPS - 1)) begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: state_next = ST_MUL_B;
            ST_MUL_B: state_next = ST_MUL_C;
            ST_MUL_C: begin
                pass_next  = 1'b1;
                state_next = pass_reg ? ST_ADD_A : ST_MUL_A;
            end
            ST_ADD_A: state_next = ST_ADD_B;
            ST_ADD_B: state_next = ST_ADD_C;
            ST_ADD_C: state_next = ST_ADD_D;
            ST_ADD_D: state_next = ST_COMMIT;
            ST_COMMIT: begin
                if (!status.commit_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
        end
    end

    // Decode commands
    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.load     = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.dot_step = (state_reg == ST_DOT);
    assign cmd.mul_sel  = pass_reg;
    assign cmd.mul_a    = (state_reg == ST_MUL_A);
    assign cmd.mul_b    = (state_reg == ST_MUL_B);
    assign cmd.mul_c    = (state_reg == ST_MUL_C);
    assign cmd.add_a    = (state_reg == ST_ADD_A);
    assign cmd.add_b    = (state_reg == ST_ADD_B);
    assign cmd.add_c    = (state_reg == ST_ADD_C);
    assign cmd.add_d    = (state_reg == ST_ADD_D);
    assign cmd.commit   = (state_reg == ST_COMMIT) && !status.commit_stall;

endmodule

FILE: hdl/qbsd_datapath.sv
// Datapath: integer dot lanes, shared fp32 multiplier, fp32 adder, row counters, output register.
module qbsd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qbsd_pkg::dp_cmd_t                   cmd,
    output qbsd_pkg::dp_status_t                status,
    input  logic [559:0]                        s_tdata,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [qbsd_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,
    output logic                                m_tlast
);

    // Configuration
    logic [qbsd_pkg::BPR_W-1:0]  bpr_reg;
    logic [qbsd_pkg::ROWS_W-1:0] rows_reg;
    logic [qbsd_pkg::BPR_W-1:0]  bpr_eff;
    logic [qbsd_pkg::ROWS_W-1:0] rows_eff;

    // Captured transaction
    logic [15:0]  ws_reg;
    logic [31:0]  as_reg;
    logic [255:0] w_sh_reg;
    logic [255:0] a_sh_reg;
    logic signed [qbsd_pkg::DOT_W-1:0] dot_reg;
    logic signed [qbsd_pkg::DOT_W-1:0] psum;

    // Multiplier
    qbsd_pkg::fp_unp_t  ua_reg, ub_reg;
    logic [31:0]        dotf_reg, dotf_next;
    logic [31:0]        scale_reg, term_reg;
    logic [47:0]        mp_reg;
    logic signed [11:0] me_reg;
    logic               msgn_reg, msp_reg;
    logic [31:0]        mspbits_reg;
    logic [31:0]        mul_res;

    // Adder
    logic [31:0]        acc_reg, sum_reg;
    logic               ad_sgn_reg, ad_sub_reg, ad_sp_reg, ad_zero_reg;
    logic [31:0]        ad_spbits_reg;
    logic signed [11:0] ad_e_reg, ad_ne_reg;
    logic [26:0]        ad_ma_reg, ad_mb_reg;
    logic [27:0]        ad_s_reg;
    logic [47:0]        ad_m_reg;

    // Row tracking and output
    logic [qbsd_pkg::POS_W-1:0] pos_reg;
    logic [qbsd_pkg::ROW_W-1:0] row_reg;
    logic                       last_block, last_row;
    logic                       out_valid_reg, out_last_reg;
    logic [47:0]                out_data_reg;
    logic [31:0]                sum_canon;

    // Clamp register values to their legal ranges
    always_comb begin
        if (bpr_reg == '0) begin
            bpr_eff = 14'd1;
        end else if (bpr_reg > qbsd_pkg::BPR_MAX) begin
            bpr_eff = qbsd_pkg::BPR_MAX;
        end else begin
            bpr_eff = bpr_reg;
        end
        if (rows_reg == '0) begin
            rows_eff = 17'd1;
        end else if (rows_reg > qbsd_pkg::ROWS_MAX) begin
            rows_eff = qbsd_pkg::ROWS_MAX;
        end else begin
            rows_eff = rows_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpr_reg  <= 14'd1;
            rows_reg <= 17'd1;
        end else if (cfg_wr_en) begin
            unique case (qbsd_pkg::cfg_index_t'(cfg_addr))
                qbsd_pkg::CFG_BLOCKS_PER_ROW: bpr_reg  <= cfg_wr_data[qbsd_pkg::BPR_W-1:0];
                qbsd_pkg::CFG_ROW_COUNT:      rows_reg <= cfg_wr_data;
                default:                      bpr_reg  <= bpr_reg;
            endcase
        end
    end

    // Eight signed byte products per step
    always_comb begin
        logic signed [15:0] p;
        psum = dot_reg;
        for (int i = 0; i < qbsd_pkg::LANES; i++) begin
            p    = $signed(w_sh_reg[8*i +: 8]) * $signed(a_sh_reg[8*i +: 8]);
            psum = psum + {{(qbsd_pkg::DOT_W-16){p[15]}}, p};
        end
    end

    // Capture transaction and run the dot lanes
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ws_reg   <= s_tdata[15:0];
            as_reg   <= s_tdata[47:16];
            w_sh_reg <= s_tdata[303:48];
            a_sh_reg <= s_tdata[559:304];
            dot_reg  <= '0;
        end else if (cmd.dot_step) begin
            w_sh_reg <= w_sh_reg >> 64;
            a_sh_reg <= a_sh_reg >> 64;
            dot_reg  <= psum;
        end
    end

    // Convert the integer dot product to fp32 (exact)
    always_comb begin
        logic [19:0] mag;
        logic [5:0]  lz;
        mag = dot_reg[20] ? 20'(-dot_reg) : dot_reg[19:0];
        lz  = qbsd_pkg::lzc48({mag, 28'd0});
        if (mag == '0) begin
            dotf_next = '0;
        end else begin
            dotf_next = qbsd_pkg::round_pack(dot_reg[20], 12'sd146 - $signed({6'd0, lz}),
                                             {mag, 28'd0} << lz);
        end
    end

    // Multiplier stage A: select and unpack operands
    always_ff @(posedge aclk) begin
        if (cmd.mul_a) begin
            if (cmd.mul_sel) begin
                ua_reg <= qbsd_pkg::unpack(scale_reg);
                ub_reg <= qbsd_pkg::unpack(dotf_reg);
            end else begin
                ua_reg   <= qbsd_pkg::unpack(qbsd_pkg::half_to_bits(ws_reg));
                ub_reg   <= qbsd_pkg::unpack(as_reg);
                dotf_reg <= dotf_next;
            end
        end
    end

    // Multiplier stage B: mantissa product and special cases
    always_ff @(posedge aclk) begin
        logic nan, inf, zero, sg;
        nan  = ua_reg.nan | ub_reg.nan | (ua_reg.inf & ub_reg.zero) | (ua_reg.zero & ub_reg.inf);
        inf  = ua_reg.inf | ub_reg.inf;
        zero = ua_reg.zero | ub_reg.zero;
        sg   = ua_reg.sgn ^ ub_reg.sgn;
        if (cmd.mul_b) begin
            mp_reg   <= ua_reg.man * ub_reg.man;
            me_reg   <= {ua_reg.exp[10], ua_reg.exp} + {ub_reg.exp[10], ub_reg.exp} - 12'sd127;
            msgn_reg <= sg;
            msp_reg  <= nan | inf | zero;
            if (nan) begin
                mspbits_reg <= qbsd_pkg::QNAN;
            end else if (inf) begin
                mspbits_reg <= {sg, 8'hFF, 23'd0};
            end else begin
                mspbits_reg <= {sg, 31'd0};
            end
        end
    end

    // Multiplier stage C: normalize by one and round
    always_comb begin
        if (msp_reg) begin
            mul_res = mspbits_reg;
        end else if (mp_reg[47]) begin
            mul_res = qbsd_pkg::round_pack(msgn_reg, me_reg + 12'sd1, mp_reg);
        end else begin
            mul_res = qbsd_pkg::round_pack(msgn_reg, me_reg, mp_reg << 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_c) begin
            if (cmd.mul_sel) begin
                term_reg <= mul_res;
            end else begin
                scale_reg <= mul_res;
            end
        end
    end

    // Adder stage A: special cases, order by magnitude, align
    always_ff @(posedge aclk) begin
        qbsd_pkg::fp_unp_t  xa, xb, big, sml;
        logic signed [11:0] d;
        logic [4:0]         dc;
        logic [26:0]        ms;
        xa  = qbsd_pkg::unpack(acc_reg);
        xb  = qbsd_pkg::unpack(term_reg);
        if ((xa.exp > xb.exp) || ((xa.exp == xb.exp) && (xa.man >= xb.man))) begin
            big = xa;
            sml = xb;
        end else begin
            big = xb;
            sml = xa;
        end
        d  = {big.exp[10], big.exp} - {sml.exp[10], sml.exp};
        dc = (d > 12'sd27) ? 5'd27 : d[4:0];
        ms = {sml.man, 3'd0};
        if (cmd.add_a) begin
            ad_sgn_reg <= big.sgn;
            ad_sub_reg <= big.sgn ^ sml.sgn;
            ad_e_reg   <= {big.exp[10], big.exp};
            ad_ma_reg  <= {big.man, 3'd0};
            ad_mb_reg  <= (ms >> dc) | {26'd0, |(ms & ~({27{1'b1}} << dc))};
            ad_sp_reg  <= xa.nan | xb.nan | xa.inf | xb.inf | xa.zero | xb.zero;
            if (xa.nan || xb.nan || (xa.inf && xb.inf && (xa.sgn != xb.sgn))) begin
                ad_spbits_reg <= qbsd_pkg::QNAN;
            end else if (xa.inf) begin
                ad_spbits_reg <= acc_reg;
            end else if (xb.inf) begin
                ad_spbits_reg <= term_reg;
            end else if (xa.zero && xb.zero) begin
                ad_spbits_reg <= {xa.sgn & xb.sgn, 31'd0};
            end else if (xa.zero) begin
                ad_spbits_reg <= term_reg;
            end else begin
                ad_spbits_reg <= acc_reg;
            end
        end
    end

    // Adder stage B: add or subtract magnitudes
    always_ff @(posedge aclk) begin
        if (cmd.add_b) begin
            if (ad_sub_reg) begin
                ad_s_reg <= {1'b0, ad_ma_reg} - {1'b0, ad_mb_reg};
            end else begin
                ad_s_reg <= {1'b0, ad_ma_reg} + {1'b0, ad_mb_reg};
            end
        end
    end

    // Adder stage C: normalize
    always_ff @(posedge aclk) begin
        logic [5:0] lz;
        lz = qbsd_pkg::lzc48({ad_s_reg, 20'd0});
        if (cmd.add_c) begin
            ad_zero_reg <= (ad_s_reg == '0);
            ad_m_reg    <= {ad_s_reg, 20'd0} << lz;
            ad_ne_reg   <= ad_e_reg + 12'sd1 - $signed({6'd0, lz});
        end
    end

    // Adder stage D: round
    always_ff @(posedge aclk) begin
        if (cmd.add_d) begin
            if (ad_sp_reg) begin
                sum_reg <= ad_spbits_reg;
            end else if (ad_zero_reg) begin
                sum_reg <= '0;
            end else begin
                sum_reg <= qbsd_pkg::round_pack(ad_sgn_reg, ad_ne_reg, ad_m_reg);
            end
        end
    end

    // Row bookkeeping
    assign last_block = ({1'b0, pos_reg} + 14'd1) >= bpr_eff;
    assign last_row   = ({1'b0, row_reg} + 17'd1) >= rows_eff;
    assign sum_canon  = ((sum_reg[30:23] == 8'hFF) && (sum_reg[22:0] != '0)) ?
                        qbsd_pkg::QNAN : sum_reg;
    assign status.commit_stall = last_block && out_valid_reg && !m_tready;

    // Commit the block: update accumulator, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            pos_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.commit) begin
                if (last_block) begin
                    acc_reg       <= '0;
                    pos_reg       <= '0;
                    row_reg       <= last_row ? '0 : row_reg + 16'd1;
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= {row_reg, sum_canon};
                    out_last_reg  <= last_row;
                end else begin
                    acc_reg <= sum_reg;
                    pos_reg <= pos_reg + 13'd1;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hdl/q8_block_scaled_dot_product_unit.sv
// Top level of the Q8_0 block-scaled dot product unit.
// Takes a new transaction only after the previous one commits: 8-lane byte products, two passes
// through the shared 3-stage fp32 multiplier, the fp32 adder stages and a commit step.
// A row result enters the output register when the transaction of its last block commits.
// The output register lets the next transaction in while a result waits; only a new
// row result stalls on a full output. Synchronous active-low reset clears the
// accumulator, counters and output valid, and sets both count registers to 1.
module q8_block_scaled_dot_product_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // weight_scale, act_scale, weight_quads_a..d, act_quads_a..d (lowest bit up)
    input  logic [559:0]                        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // row_sum, row_index (lowest bit up)
    output logic [47:0]                         m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [qbsd_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    qbsd_pkg::dp_cmd_t    cmd;
    qbsd_pkg::dp_status_t status;

    qbsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qbsd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: test/q8_block_scaled_dot_product_checker.sv
// Checker for the Q8_0 dot product unit: watches both channels, predicts row sums, compares.
`timescale 1ns / 1ps

module q8_block_scaled_dot_product_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [559:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [qbsd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output int           mismatches,
    output int           rows_seen,
    output int           awaiting
);

    typedef struct packed {
        logic [31:0] row_sum;
        logic [15:0] row_index;
        logic        final_row;
    } row_result_t;

    typedef struct {
        logic        sgn;
        int          e;
        logic [23:0] m;
        logic        is_zero;
        logic        is_inf;
        logic        is_nan;
    } fp_parts_t;

    row_result_t  pending_rows[$];
    logic [13:0]  bpr_reg;
    logic [16:0]  rows_reg;
    logic [31:0]  acc;
    int unsigned  block_pos;
    int unsigned  row_now;

    // Round m * 2^e to fp32, nearest even, subnormals kept
    function automatic logic [31:0] fp_round(input logic sgn, input int e,
                                             input logic [65:0] m);
        int          p;
        int          sh;
        logic [65:0] q;
        logic [65:0] rem;
        logic [65:0] half;
        longint      bits;
        if (m == '0) begin
            return {sgn, 31'd0};
        end
        p = 0;
        for (int i = 0; i < 66; i++) begin
            if (m[i]) begin
                p = i;
            end
        end
        sh = p - 23;
        if (sh < -149 - e) begin
            sh = -149 - e;
        end
        if (sh > 66) begin
            return {sgn, 31'd0};
        end
        if (sh > 0) begin
            q    = m >> sh;
            rem  = m & ((66'd1 << sh) - 66'd1);
            half = 66'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) begin
                q = q + 66'd1;
            end
        end else begin
            q = m << (-sh);
        end
        bits = longint'(sh + e + 149) * 64'd8388608 + longint'(q);
        if (bits >= 64'h7F800000) begin
            bits = 64'h7F800000;
        end
        return {sgn, bits[30:0]};
    endfunction

    // Split an fp32 pattern into sign, lsb exponent and integer mantissa
    function automatic fp_parts_t split(input logic [31:0] b);
        fp_parts_t r;
        r.sgn     = b[31];
        r.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 0);
        r.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 0);
        r.is_zero = (b[30:0] == 0);
        if (b[30:23] == 8'd0) begin
            r.m = {1'b0, b[22:0]};
            r.e = -149;
        end else begin
            r.m = {1'b1, b[22:0]};
            r.e = int'(b[30:23]) - 150;
        end
        return r;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        fp_parts_t x;
        fp_parts_t y;
        logic      s;
        x = split(a);
        y = split(b);
        s = x.sgn ^ y.sgn;
        if (x.is_nan || y.is_nan || (x.is_inf && y.is_zero) || (y.is_inf && x.is_zero)) begin
            return qbsd_pkg::QNAN;
        end
        if (x.is_inf || y.is_inf) begin
            return {s, 8'hFF, 23'd0};
        end
        if (x.is_zero || y.is_zero) begin
            return {s, 31'd0};
        end
        return fp_round(s, x.e + y.e, 66'(x.m) * 66'(y.m));
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        fp_parts_t   x;
        fp_parts_t   y;
        fp_parts_t   t;
        int          d;
        logic [65:0] big;
        logic [65:0] lit;
        x = split(a);
        y = split(b);
        if (x.is_nan || y.is_nan || (x.is_inf && y.is_inf && x.sgn != y.sgn)) begin
            return qbsd_pkg::QNAN;
        end
        if (x.is_inf) begin
            return a;
        end
        if (y.is_inf) begin
            return b;
        end
        if (x.is_zero && y.is_zero) begin
            return {x.sgn & y.sgn, 31'd0};
        end
        if (x.is_zero) begin
            return b;
        end
        if (y.is_zero) begin
            return a;
        end
        // keep x as the operand with the higher lsb exponent
        if (x.e < y.e) begin
            t = x;
            x = y;
            y = t;
        end
        d   = x.e - y.e;
        lit = 66'(y.m);
        // a far smaller operand only matters as a sticky bit
        if (d > 40) begin
            d   = 40;
            lit = 66'd1;
        end
        big = 66'(x.m) << d;
        if (x.sgn == y.sgn) begin
            return fp_round(x.sgn, x.e - d, big + lit);
        end
        if (big == lit) begin
            return 32'd0;
        end
        if (big > lit) begin
            return fp_round(x.sgn, x.e - d, big - lit);
        end
        return fp_round(y.sgn, x.e - d, lit - big);
    endfunction

    function automatic logic [31:0] half_widen(input logic [15:0] h);
        if (h[14:10] == 5'd0) begin
            return fp_round(h[15], -24, 66'(h[9:0]));
        end
        if (h[14:10] == 5'd31) begin
            return {h[15], 8'hFF, h[9:0], 13'd0};
        end
        return {h[15], 3'd0 + h[14:10] + 8'd112, h[9:0], 13'd0};
    endfunction

    // Block term: (fp32(weight scale) * act scale) * fp32(integer dot)
    function automatic logic [31:0] block_term(input logic [559:0] d);
        int          idot;
        logic [31:0] dot_f;
        idot = 0;
        for (int i = 0; i < qbsd_pkg::BLOCK_ELEMENTS; i++) begin
            idot += int'($signed(d[48 + i*8 +: 8])) * int'($signed(d[304 + i*8 +: 8]));
        end
        dot_f = fp_round(idot < 0, 0, 66'(idot < 0 ? -idot : idot));
        return fp_mul(fp_mul(half_widen(d[15:0]), d[47:16]), dot_f);
    endfunction

    function automatic int unsigned clamp_count(input int unsigned v, input int unsigned top);
        if (v == 0) begin
            return 1;
        end
        return (v > top) ? top : v;
    endfunction

    assign awaiting = pending_rows.size();

    always @(posedge aclk) begin
        row_result_t exp_row;
        row_result_t got_row;
        logic [31:0] sum;
        int unsigned rows_eff;
        if (!aresetn) begin
            bpr_reg    <= 14'd1;
            rows_reg   <= 17'd1;
            acc        <= 32'd0;
            block_pos  <= 0;
            row_now    <= 0;
            mismatches <= 0;
            rows_seen  <= 0;
            pending_rows.delete();
        end else begin
            // track register writes
            if (cfg_wr_en) begin
                if (cfg_addr == qbsd_pkg::CFG_BLOCKS_PER_ROW) begin
                    bpr_reg <= cfg_wr_data[13:0];
                end else begin
                    rows_reg <= cfg_wr_data[16:0];
                end
            end
            // predict on each accepted input transaction
            if (s_tvalid && s_tready) begin
                sum = fp_add(acc, block_term(s_tdata));
                if (block_pos + 1 < clamp_count(bpr_reg, 8192)) begin
                    acc       <= sum;
                    block_pos <= block_pos + 1;
                end else begin
                    rows_eff = clamp_count(rows_reg, 65536);
                    if (sum[30:23] == 8'hFF && sum[22:0] != 0) begin
                        sum = qbsd_pkg::QNAN;
                    end
                    exp_row.row_sum   = sum;
                    exp_row.row_index = row_now[15:0];
                    exp_row.final_row = (row_now + 1 >= rows_eff);
                    pending_rows.push_back(exp_row);
                    acc       <= 32'd0;
                    block_pos <= 0;
                    row_now   <= exp_row.final_row ? 0 : ((row_now + 1) & 32'hFFFF);
                end
            end
            // compare each result transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                got_row = {m_tdata[31:0], m_tdata[47:32], m_tlast};
                rows_seen <= rows_seen + 1;
                if (pending_rows.size() == 0) begin
                    $display("%0t: unexpected result sum=%h row=%0d last=%b", $time,
                             got_row.row_sum, got_row.row_index, got_row.final_row);
                    mismatches <= mismatches + 1;
                end else begin
                    exp_row = pending_rows.pop_front();
                    if (got_row.row_sum !== exp_row.row_sum) begin
                        $display("%0t: row_sum expected %h actual %h", $time,
                                 exp_row.row_sum, got_row.row_sum);
                    end
                    if (got_row.row_index !== exp_row.row_index) begin
                        $display("%0t: row_index expected %0d actual %0d", $time,
                                 exp_row.row_index, got_row.row_index);
                    end
                    if (got_row.final_row !== exp_row.final_row) begin
                        $display("%0t: final_row expected %b actual %b", $time,
                                 exp_row.final_row, got_row.final_row);
                    end
                    if (got_row !== exp_row) begin
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: test/tb_q8_block_scaled_dot_product_unit.sv
// Testbench top for the Q8_0 dot product unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_q8_block_scaled_dot_product_unit;

    localparam int ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [559:0] s_tdata     = '0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [47:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_wr_en   = 1'b0;
    logic         cfg_addr    = qbsd_pkg::CFG_BLOCKS_PER_ROW;
    logic [qbsd_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    int   mismatches;
    int   rows_seen;
    int   awaiting;
    int   items_sent  = 0;
    int   burst_left  = 1;
    logic gaps_on     = 1'b1;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;

    q8_block_scaled_dot_product_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    q8_block_scaled_dot_product_checker row_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .mismatches(mismatches), .rows_seen(rows_seen), .awaiting(awaiting)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [559:0] block_pair(input logic [15:0] ws, input logic [31:0] as,
                                                input logic [255:0] w, input logic [255:0] a);
        return {a, w, as, ws};
    endfunction

    function automatic logic [255:0] rand_quads();
        logic [255:0] q;
        for (int i = 0; i < 8; i++) begin
            q[i*32 +: 32] = $urandom;
        end
        return q;
    endfunction

    // Mostly moderate scales so sums stay finite, with some fully random patterns
    function automatic logic [559:0] rand_block();
        logic [15:0] ws;
        logic [31:0] as;
        if ($urandom_range(0, 9) < 7) begin
            ws = {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
        end else begin
            ws = 16'($urandom);
        end
        if ($urandom_range(0, 9) < 7) begin
            as = {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
        end else begin
            as = $urandom;
        end
        return block_pair(ws, as, rand_quads(), rand_quads());
    endfunction

    // Offer one block and hold until accepted; valid stays high afterwards unless a gap is due
    task automatic send_block(input logic [559:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++) begin
            send_block(rand_block());
        end
    endtask

    // Stop offering, let every expected row arrive and the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input qbsd_pkg::cfg_index_t idx,
                             input logic [qbsd_pkg::CFG_DATA_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: stall pattern of its own, plus one long hold-off on request
    initial begin
        int mode;
        int span;
        mode = 0;
        span = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_done = 1'b1;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(50, 200);
            end
            span--;
            case (mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= 1'($urandom);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 4) == 0);
                end
            endcase
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [255:0] ones;
        logic [255:0] w7f;
        logic [255:0] w80;
        int           phase;
        ones = {32{8'h01}};
        w7f  = {32{8'h7F}};
        w80  = {32{8'h80}};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed blocks at reset settings: one block per row, one row per pass
        gaps_on = 1'b0;
        send_block(block_pair(16'h3C00, 32'h3F800000, '0, '0));
        send_block(block_pair(16'h3C00, 32'h3F800000, w7f, w80));
        send_block(block_pair(16'h3C00, 32'h3F800000, w80, w80));
        send_block(block_pair(16'h3C00, 32'h3F800000, w7f, w7f));
        send_block(block_pair(16'hFFFF, 32'h3F800000, ones, ones));
        send_block(block_pair(16'h7C00, 32'h3F800000, ones, ones));
        send_block(block_pair(16'h7C00, 32'h3F800000, '0, ones));
        send_block(block_pair(16'h0001, 32'h00000001, ones, ones));
        send_block(block_pair(16'h03FF, 32'h00800000, ones, ones));
        send_block(block_pair(16'h7BFF, 32'h7F7FFFFF, w80, w80));
        send_block(block_pair(16'h8000, 32'h3F800000, ones, ones));
        send_block(block_pair(16'h3C00, 32'hFFFFFFFF, ones, ones));
        send_block(block_pair(16'h3C00, 32'h80000000, ones, ones));
        send_block(block_pair(16'h3C00, 32'hFF800000, ones, w80));
        drain();

        // Rows of three: opposite infinities, then exact cancellation
        write_reg(qbsd_pkg::CFG_BLOCKS_PER_ROW, 17'd3);
        write_reg(qbsd_pkg::CFG_ROW_COUNT, 17'd2);
        send_block(block_pair(16'h7C00, 32'h3F800000, ones, ones));
        send_block(block_pair(16'hFC00, 32'h3F800000, ones, ones));
        send_block(block_pair(16'h3C00, 32'h3F800000, ones, ones));
        send_block(block_pair(16'h3C00, 32'h40000000, ones, ones));
        send_block(block_pair(16'hBC00, 32'h40000000, ones, ones));
        send_block(block_pair(16'h0000, 32'h40000000, ones, ones));
        drain();

        // Out-of-range register values that must clamp; upper data bits ignored
        gaps_on = 1'b1;
        write_reg(qbsd_pkg::CFG_BLOCKS_PER_ROW, 17'h1C003);
        write_reg(qbsd_pkg::CFG_ROW_COUNT, 17'd0);
        send_random(30);
        drain();
        write_reg(qbsd_pkg::CFG_BLOCKS_PER_ROW, 17'd0);
        write_reg(qbsd_pkg::CFG_ROW_COUNT, 17'd5);
        send_random(40);
        drain();

        // Largest row length, shortened mid-row
        write_reg(qbsd_pkg::CFG_BLOCKS_PER_ROW, 17'h3FFF);
        write_reg(qbsd_pkg::CFG_ROW_COUNT, 17'd3);
        send_random(7);
        drain();
        write_reg(qbsd_pkg::CFG_BLOCKS_PER_ROW, 17'd2);
        send_random(20);
        drain();

        // Largest pass, shortened mid-pass
        write_reg(qbsd_pkg::CFG_BLOCKS_PER_ROW, 17'd1);
        write_reg(qbsd_pkg::CFG_ROW_COUNT, 17'h1FFFF);
        send_random(12);
        drain();
        write_reg(qbsd_pkg::CFG_ROW_COUNT, 17'd4);
        send_random(20);
        drain();

        // Random settings until the item budget is spent
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase == 3) begin
                write_reg(qbsd_pkg::CFG_BLOCKS_PER_ROW, 17'd1);
                hold_req <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                write_reg(qbsd_pkg::CFG_BLOCKS_PER_ROW, 17'($urandom_range(1, 40)));
            end else begin
                write_reg(qbsd_pkg::CFG_BLOCKS_PER_ROW, 17'($urandom_range(1, 6)));
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg(qbsd_pkg::CFG_ROW_COUNT, 17'd0);
            end else begin
                write_reg(qbsd_pkg::CFG_ROW_COUNT, 17'($urandom_range(1, 5)));
            end
            gaps_on = (phase % 4 != 1);
            send_random($urandom_range(30, 100));
            drain();
            phase++;
        end

        $display("covered %0d blocks and %0d row results over %0d random phases",
                 items_sent, rows_seen, phase);
        $display("including special scales, register clamping and mid-row changes");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/qbsd_pkg.sv
hdl/qbsd_ctrl.sv
hdl/qbsd_datapath.sv
hdl/q8_block_scaled_dot_product_unit.sv
test/q8_block_scaled_dot_product_checker.sv
test/tb_q8_block_scaled_dot_product_unit.sv
